>>> rtl/lfs_pkg.sv
// Shared types, widths and register codes for the 1-D Lee filter stream core.
package lfs_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int FRAC_BITS       = 8;
    localparam int GAIN_BITS       = 16;
    localparam int MAX_HALF_WINDOW = 31;
    localparam int HW_W            = 5;
    localparam int NV_W            = 32;
    localparam int FILT_W          = 24;
    localparam int CFG_IDX_W       = 1;

    // Widths cover the whole range of the half-window limit.
    localparam int WIN_W  = $clog2(2 * MAX_HALF_WINDOW + 2);
    localparam int MEAN_W = SAMPLE_W + FRAC_BITS;
    localparam int DV_W   = SAMPLE_W + FRAC_BITS + 1;
    localparam int SQ_W   = 2 * (DV_W - 1);
    localparam int SUM_W  = SAMPLE_W + WIN_W + 1;
    localparam int DEV_W  = SQ_W + WIN_W;
    localparam int VAR_W  = SQ_W - FRAC_BITS + 1;
    localparam int GAIN_W = GAIN_BITS + 1;
    localparam int PROD_W = DV_W + GAIN_W + 1;

    // Divider chain: one quotient bit per cell.
    localparam int DIV_N = VAR_W + GAIN_BITS;
    localparam int DIV_D = VAR_W;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_VAR   = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in;
    } smp_t;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic                     last_out;
    } res_t;

    typedef struct packed {
        logic             vld;
        logic [DIV_D-1:0] rem;
        logic [DIV_N-1:0] num;
        logic [DIV_D-1:0] den;
    } div_cell_t;

endpackage

>>> rtl/lee_filter_1d_stream_core.sv
// Top level of the 1-D Lee filter stream core: sequencer, delay stores, divider chain and output register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------
//  smp      | smp_valid / smp_stall   | smp_data  (sample, last_in)
//  res      | res_valid / res_stall   | res_data  (filtered, last_out)
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One sample is taken at a time. Each mean costs window reads plus one pass of the
//  divider chain; each result costs reads and squares plus up to two passes of the
//  divider chain, and a last sample repeats this per flushed result.
//  Reset clears control state; the delay stores need no clearing pass.
//  A stalled result holds in the output register and the sequencer waits there.
module lee_filter_1d_stream_core
    import lfs_pkg::*;
#(
    parameter int HALF_WINDOW_LIMIT = MAX_HALF_WINDOW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 smp_valid,
    output logic                 smp_stall,
    input  smp_t                 smp_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NV_W-1:0]      cfg_data
);

    localparam int DEPTH = 2 ** $clog2(3 * HALF_WINDOW_LIMIT + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $clog2(HALF_WINDOW_LIMIT + 1);
    localparam int A_W   = SUM_W + FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PLAN, ST_MEAN_RUN, ST_MEAN_DIV, ST_DEV_RUN,
        ST_VAR_DIV, ST_GAIN_DIV, ST_FILT_MUL, ST_FILT_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_FIRST, PH_SINGLE, PH_DONE, PH_LMEAN, PH_LFILT, PH_LEND
    } phase_t;

    state_t                    state_reg;
    phase_t                    ph_reg;
    logic [HW_W-1:0]           hw_reg;
    logic [NV_W-1:0]           nv_reg;
    logic [AW-1:0]             wr_ptr_reg;
    logic [AW-1:0]             items_reg;
    logic [AW-1:0]             k_reg;
    logic [MW-1:0]             m_reg;
    logic                      last_reg;
    logic [AW-1:0]             di_reg;
    logic [AW-1:0]             tgt_reg;
    logic [AW-1:0]             t_reg;
    logic [AW-1:0]             t1_reg;
    logic [AW-1:0]             hi_reg;
    logic                      iss_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      out_last_reg;
    logic                      neg_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [DEV_W-1:0]          dev_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [SAMPLE_W-1:0] xs_reg;
    logic signed [MEAN_W-1:0]  mm_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      res_valid_reg;
    res_t                      res_reg;
    div_cell_t                 div_in_reg;
    div_cell_t                 div_out;

    logic signed [SAMPLE_W-1:0] smem [DEPTH];
    logic signed [MEAN_W-1:0]   mmem [DEPTH];
    logic signed [SAMPLE_W-1:0] s_rd_reg;
    logic signed [MEAN_W-1:0]   m_rd_reg;

    logic                      smp_fire;
    logic [MW-1:0]             m_clamp;
    logic [AW-1:0]             m_ext;
    logic [AW-1:0]             two_m;
    logic [AW-1:0]             win;
    logic [AW-1:0]             plan_tgt;
    logic [AW-1:0]             plan_lo;
    logic [AW-1:0]             plan_hi;
    logic [AW:0]               plan_top;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             mw_addr;
    logic                      rd_en;
    logic                      mw_en;
    logic signed [A_W-1:0]     a_val;
    logic [A_W-1:0]            a_mag;
    logic [MEAN_W-1:0]         q_mean;
    logic signed [MEAN_W-1:0]  mean_val;
    logic signed [DV_W-1:0]    dv;
    logic signed [2*DV_W-1:0]  sq_full;
    logic [VAR_W-1:0]          q_var;
    logic [VAR_W-1:0]          den_sum;
    logic signed [DV_W-1:0]    diff_x;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]  res_full;

    assign smp_fire  = smp_valid && (state_reg == ST_IDLE);
    assign smp_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        m_clamp = (hw_reg > HW_W'(HALF_WINDOW_LIMIT)) ? MW'(HALF_WINDOW_LIMIT)
                                                     : hw_reg[MW-1:0];
        m_ext   = AW'(m_reg);
        two_m   = AW'({m_reg, 1'b0});
        win     = two_m + AW'(1);

        case (ph_reg)
            PH_FIRST:  plan_tgt = m_ext;
            PH_SINGLE: plan_tgt = two_m;
            PH_LMEAN:  plan_tgt = di_reg - m_ext;
            PH_LFILT:  plan_tgt = di_reg;
            default:   plan_tgt = '0;
        endcase
        plan_lo  = (plan_tgt >= m_ext) ? plan_tgt - m_ext : '0;
        plan_top = (AW+1)'(plan_tgt) + (AW+1)'(m_ext);
        plan_hi  = (plan_top <= (AW+1)'(k_reg)) ? plan_top[AW-1:0] : k_reg;

        rd_en   = iss_reg && ((state_reg == ST_MEAN_RUN) || (state_reg == ST_DEV_RUN));
        rd_addr = wr_ptr_reg - AW'(1) - t_reg;
        mw_addr = wr_ptr_reg - AW'(1) - tgt_reg;
        mw_en   = (state_reg == ST_MEAN_DIV) && div_out.vld;

        // Floor division of a signed sum: divide the magnitude, biased when negative.
        a_val    = $signed({sum_reg, {FRAC_BITS{1'b0}}});
        a_mag    = sum_reg[SUM_W-1] ? A_W'(-a_val) + A_W'(win) - A_W'(1) : A_W'(a_val);
        q_mean   = div_out.num[MEAN_W-1:0];
        mean_val = neg_reg ? -$signed(q_mean) : $signed(q_mean);

        dv      = $signed({s_rd_reg[SAMPLE_W-1], s_rd_reg, {FRAC_BITS{1'b0}}})
                  - DV_W'(m_rd_reg);
        sq_full = dv * dv;

        q_var   = div_out.num[VAR_W-1:0];
        den_sum = q_var + VAR_W'(nv_reg);

        diff_x    = $signed({xs_reg[SAMPLE_W-1], xs_reg, {FRAC_BITS{1'b0}}})
                    - DV_W'(mm_reg);
        prod_full = PROD_W'(diff_x) * $signed({1'b0, gain_reg});
        res_full  = (prod_reg >>> GAIN_BITS) + PROD_W'(mm_reg);
    end

    // Delay stores, indexed by age from the write pointer.
    always_ff @(posedge clk)
    begin
        if (smp_fire)
        begin
            smem[wr_ptr_reg] <= smp_data.sample;
        end
        if (mw_en)
        begin
            mmem[mw_addr] <= mean_val;
        end
        if (rd_en)
        begin
            s_rd_reg <= smem[rd_addr];
            m_rd_reg <= mmem[rd_addr];
        end
    end

    lfs_div_chain u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (div_in_reg),
        .dout  (div_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_FIRST;
            hw_reg        <= HW_W'(2);
            nv_reg        <= NV_W'(256);
            wr_ptr_reg    <= '0;
            items_reg     <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            last_reg      <= 1'b0;
            di_reg        <= '0;
            tgt_reg       <= '0;
            t_reg         <= '0;
            t1_reg        <= '0;
            hi_reg        <= '0;
            iss_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_last_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            sum_reg       <= '0;
            dev_reg       <= '0;
            sq_reg        <= '0;
            gain_reg      <= '0;
            xs_reg        <= '0;
            mm_reg        <= '0;
            prod_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            div_in_reg    <= '0;
        end
        else
        begin
            div_in_reg.vld <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_HALF_WINDOW: hw_reg <= cfg_data[HW_W-1:0];
                    REG_NOISE_VAR:   nv_reg <= cfg_data;
                    default:         ;
                endcase
            end

            // Drop the result once its transfer completes.
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (smp_fire)
                    begin
                        if (items_reg == '0)
                        begin
                            m_reg <= m_clamp;
                        end
                        k_reg      <= items_reg;
                        items_reg  <= (items_reg == AW'(DEPTH - 1)) ? items_reg
                                                                    : items_reg + AW'(1);
                        wr_ptr_reg <= wr_ptr_reg + AW'(1);
                        last_reg   <= smp_data.last_in;
                        ph_reg     <= PH_FIRST;
                        state_reg  <= ST_PLAN;
                    end
                end

                ST_PLAN:
                begin
                    tgt_reg <= plan_tgt;
                    t_reg   <= plan_lo;
                    hi_reg  <= plan_hi;
                    iss_reg <= 1'b0;
                    v1_reg  <= 1'b0;
                    v2_reg  <= 1'b0;
                    sum_reg <= '0;
                    dev_reg <= '0;
                    case (ph_reg)
                        PH_FIRST:
                        begin
                            ph_reg <= last_reg ? PH_LMEAN : PH_SINGLE;
                            di_reg <= two_m;
                            if (m_ext <= k_reg)
                            begin
                                iss_reg   <= 1'b1;
                                state_reg <= ST_MEAN_RUN;
                            end
                        end
                        PH_SINGLE:
                        begin
                            if (two_m <= k_reg)
                            begin
                                out_last_reg <= 1'b0;
                                ph_reg       <= PH_DONE;
                                iss_reg      <= 1'b1;
                                state_reg    <= ST_DEV_RUN;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        PH_LMEAN:
                        begin
                            ph_reg <= PH_LFILT;
                            if ((di_reg >= m_ext) && (di_reg < two_m) && (plan_tgt <= k_reg))
                            begin
                                iss_reg   <= 1'b1;
                                state_reg <= ST_MEAN_RUN;
                            end
                        end
                        PH_LFILT:
                        begin
                            if (di_reg == '0)
                            begin
                                ph_reg <= PH_LEND;
                            end
                            else
                            begin
                                di_reg <= di_reg - AW'(1);
                                ph_reg <= PH_LMEAN;
                            end
                            if (di_reg <= k_reg)
                            begin
                                out_last_reg <= (di_reg == '0);
                                iss_reg      <= 1'b1;
                                state_reg    <= ST_DEV_RUN;
                            end
                        end
                        PH_LEND:
                        begin
                            items_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end

                ST_MEAN_RUN:
                begin
                    if (iss_reg)
                    begin
                        t_reg   <= t_reg + AW'(1);
                        iss_reg <= (t_reg != hi_reg);
                    end
                    v1_reg <= iss_reg;
                    if (v1_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(s_rd_reg);
                    end
                    if (!iss_reg && !v1_reg)
                    begin
                        neg_reg        <= sum_reg[SUM_W-1];
                        div_in_reg.vld <= 1'b1;
                        div_in_reg.rem <= '0;
                        div_in_reg.num <= DIV_N'(a_mag);
                        div_in_reg.den <= DIV_D'(win);
                        state_reg      <= ST_MEAN_DIV;
                    end
                end

                ST_MEAN_DIV:
                begin
                    if (div_out.vld)
                    begin
                        state_reg <= ST_PLAN;
                    end
                end

                ST_DEV_RUN:
                begin
                    if (iss_reg)
                    begin
                        t_reg   <= t_reg + AW'(1);
                        iss_reg <= (t_reg != hi_reg);
                    end
                    t1_reg <= t_reg;
                    v1_reg <= iss_reg;
                    v2_reg <= v1_reg;
                    if (v1_reg)
                    begin
                        sq_reg <= sq_full[SQ_W-1:0];
                        if (t1_reg == tgt_reg)
                        begin
                            xs_reg <= s_rd_reg;
                            mm_reg <= m_rd_reg;
                        end
                    end
                    if (v2_reg)
                    begin
                        dev_reg <= dev_reg + DEV_W'(sq_reg);
                    end
                    if (!iss_reg && !v1_reg && !v2_reg)
                    begin
                        div_in_reg.vld <= 1'b1;
                        div_in_reg.rem <= '0;
                        div_in_reg.num <= DIV_N'(dev_reg >> FRAC_BITS);
                        div_in_reg.den <= DIV_D'(win);
                        state_reg      <= ST_VAR_DIV;
                    end
                end

                ST_VAR_DIV:
                begin
                    if (div_out.vld)
                    begin
                        if (den_sum == '0)
                        begin
                            gain_reg  <= '0;
                            state_reg <= ST_FILT_MUL;
                        end
                        else
                        begin
                            div_in_reg.vld <= 1'b1;
                            div_in_reg.rem <= '0;
                            div_in_reg.num <= {q_var, {GAIN_BITS{1'b0}}};
                            div_in_reg.den <= den_sum;
                            state_reg      <= ST_GAIN_DIV;
                        end
                    end
                end

                ST_GAIN_DIV:
                begin
                    if (div_out.vld)
                    begin
                        gain_reg  <= div_out.num[GAIN_W-1:0];
                        state_reg <= ST_FILT_MUL;
                    end
                end

                ST_FILT_MUL:
                begin
                    prod_reg  <= prod_full;
                    state_reg <= ST_FILT_OUT;
                end

                ST_FILT_OUT:
                begin
                    // Hold until the output register is free.
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg    <= 1'b1;
                        res_reg.filtered <= res_full[FILT_W-1:0];
                        res_reg.last_out <= out_last_reg;
                        state_reg        <= ST_PLAN;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.vld |-> (state_reg == ST_MEAN_DIV) || (state_reg == ST_VAR_DIV)
                        || (state_reg == ST_GAIN_DIV))
        else $error("divider result outside a divide state");

    a_take_plan: assert property (@(posedge clk) disable iff (!rst_n)
        smp_fire |=> (state_reg == ST_PLAN))
        else $error("accepted sample did not start planning");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (t_reg <= hi_reg))
        else $error("window read beyond upper bound");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILT_MUL) |-> (gain_reg <= GAIN_W'(1 << GAIN_BITS)))
        else $error("gain above unity");
`endif

endmodule

>>> rtl/lfs_div_cell.sv
// One restoring division step: shifts in a dividend bit and produces one quotient bit.
module lfs_div_cell
    import lfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_cell_t cin,
    output div_cell_t cout
);

    logic             vld_reg;
    logic [DIV_D-1:0] rem_reg;
    logic [DIV_N-1:0] num_reg;
    logic [DIV_D-1:0] den_reg;
    logic [DIV_D:0]   r_sh;
    logic [DIV_D:0]   diff;
    logic             qbit;

    always_comb
    begin
        r_sh = {cin.rem, cin.num[DIV_N-1]};
        diff = r_sh - {1'b0, cin.den};
        qbit = ~diff[DIV_D];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= cin.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= qbit ? diff[DIV_D-1:0] : r_sh[DIV_D-1:0];
        num_reg <= {cin.num[DIV_N-2:0], qbit};
        den_reg <= cin.den;
    end

    always_comb
    begin
        cout.vld = vld_reg;
        cout.rem = rem_reg;
        cout.num = num_reg;
        cout.den = den_reg;
    end

endmodule

>>> rtl/lfs_div_chain.sv
// Row of division cells; the quotient leaves the last cell in the num field.
module lfs_div_chain
    import lfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_cell_t din,
    output div_cell_t dout
);

    div_cell_t link [DIV_N+1];

    assign link[0] = din;

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_cell
        lfs_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cin   (link[i]),
            .cout  (link[i+1])
        );
    end

    assign dout = link[DIV_N];

endmodule
